// File: design/udpck_pkg.sv
package udpck_pkg;

	localparam int unsigned MAX_PAYLOAD = 1472;
	localparam int unsigned SUM_W = 20;
	localparam int unsigned CFG_SUM_W = 19;

	localparam logic [15:0] UDP_HDR_BYTES = 16'd8;
	localparam logic [15:0] IP_UDP_HDR_BYTES = 16'd28;
	localparam logic [15:0] PROTO_UDP = 16'h0011;
	localparam logic [15:0] IP_VER_IHL = 16'h4500;
	localparam logic [15:0] IP_FLAGS_DF = 16'h4000;
	localparam logic [15:0] IP_TTL_PROTO = 16'h8011;

	typedef enum logic [1:0] {
		REG_SRC_IP   = 2'd0,
		REG_DST_IP   = 2'd1,
		REG_SRC_PORT = 2'd2,
		REG_DST_PORT = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_payload;
	} item_t;

	typedef struct packed {
		logic [15:0] sum;
		logic [7:0]  pending;
		logic        odd;
		logic [15:0] count;
		logic        ovf;
	} pkt_state_t;

	typedef struct packed {
		logic [15:0] udp_length;
		logic [15:0] ip_total_length;
		logic [15:0] udp_checksum;
		logic [15:0] ip_checksum;
		logic        too_long;
	} result_t;

	function automatic logic [15:0] oc_add16(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

	function automatic logic [15:0] fold20(input logic [SUM_W-1:0] x);
		logic [16:0] a;
		a = {1'b0, x[15:0]} + {13'd0, x[SUM_W-1:16]};
		return a[15:0] + {15'd0, a[16]};
	endfunction

endpackage

// File: design/udp_ipv4_checksum_engine_core.sv
// UDP over IPv4 checksum engine.
// Input channel (in_valid/in_stall): one request per payload byte. byte_present
// marks a real payload byte; end_of_payload marks the last request of a packet.
// A request with end_of_payload set yields one result on the output channel
// (out_valid/out_stall): UDP length, IP total length, UDP checksum, IPv4 header
// checksum and the too_long flag. Bytes beyond 1472 are dropped and flag too_long.
// Configuration (cfg_we/cfg_idx/cfg_wdata): source/destination address and
// ports, written by the user only while no packet is in flight (not enforced).
// A request is registered in the input register when accepted and processed
// from there; a finishing one then sets out_valid unless a held result stalls it.
// Throughput: one request per clock unless stalled; each byte passes one input
// register, the running-sum update and the checksum adder tree into the result
// register. Reset clears packet state, configuration and both valid flags.
// When the receiver stalls, the result holds; a finishing request waits in the
// input register and in_stall rises, while non-final requests keep flowing.
module udp_ipv4_checksum_engine_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        end_of_payload,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] udp_length,
	output logic [15:0] ip_total_length,
	output logic [15:0] udp_checksum,
	output logic [15:0] ip_checksum,
	output logic        too_long
);
	import udpck_pkg::*;

	localparam logic [CFG_SUM_W-1:0] CFG_UDP_RST = CFG_SUM_W'(PROTO_UDP);
	localparam logic [CFG_SUM_W-1:0] CFG_IP_RST =
		CFG_SUM_W'(IP_VER_IHL) + CFG_SUM_W'(IP_FLAGS_DF) + CFG_SUM_W'(IP_TTL_PROTO);

	logic [31:0] src_ip_q, dst_ip_q, src_ip_d, dst_ip_d;
	logic [15:0] src_port_q, dst_port_q, src_port_d, dst_port_d;
	logic [CFG_SUM_W-1:0] cfg_udp_q, cfg_ip_q, cfg_udp_d, cfg_ip_d, ip_halves;

	item_t      item_s1;
	logic       valid_s1;
	pkt_state_t st_q;
	pkt_state_t st_nxt;
	result_t    res;
	result_t    res_q;
	logic       out_valid_q;
	logic       go;
	logic       accept_in;

	always_comb begin
		src_ip_d   = src_ip_q;
		dst_ip_d   = dst_ip_q;
		src_port_d = src_port_q;
		dst_port_d = dst_port_q;
		if (cfg_we) begin
			case (cfg_idx_t'(cfg_idx))
				REG_SRC_IP:   src_ip_d   = cfg_wdata;
				REG_DST_IP:   dst_ip_d   = cfg_wdata;
				REG_SRC_PORT: src_port_d = cfg_wdata[15:0];
				REG_DST_PORT: dst_port_d = cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	assign ip_halves = CFG_SUM_W'(src_ip_d[31:16]) + CFG_SUM_W'(src_ip_d[15:0])
		+ CFG_SUM_W'(dst_ip_d[31:16]) + CFG_SUM_W'(dst_ip_d[15:0]);
	assign cfg_udp_d = ip_halves + CFG_SUM_W'(src_port_d) + CFG_SUM_W'(dst_port_d)
		+ CFG_SUM_W'(PROTO_UDP);
	assign cfg_ip_d  = ip_halves + CFG_IP_RST;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_ip_q   <= '0;
			dst_ip_q   <= '0;
			src_port_q <= '0;
			dst_port_q <= '0;
			cfg_udp_q  <= CFG_UDP_RST;
			cfg_ip_q   <= CFG_IP_RST;
		end else begin
			src_ip_q   <= src_ip_d;
			dst_ip_q   <= dst_ip_d;
			src_port_q <= src_port_d;
			dst_port_q <= dst_port_d;
			cfg_udp_q  <= cfg_udp_d;
			cfg_ip_q   <= cfg_ip_d;
		end
	end

	// advance unless a finishing request meets a held result
	assign go        = valid_s1 && (!item_s1.end_of_payload || !out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !go;
	assign accept_in = in_valid && !in_stall;

	udpck_result u_result (
		.st          (st_q),
		.item        (item_s1),
		.cfg_udp_sum (cfg_udp_q),
		.cfg_ip_sum  (cfg_ip_q),
		.st_nxt      (st_nxt),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			item_s1.data_byte      <= data_byte;
			item_s1.byte_present   <= byte_present;
			item_s1.end_of_payload <= end_of_payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (go) begin
			st_q <= item_s1.end_of_payload ? '0 : st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && item_s1.end_of_payload) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && item_s1.end_of_payload) begin
			res_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign udp_length      = res_q.udp_length;
	assign ip_total_length = res_q.ip_total_length;
	assign udp_checksum    = res_q.udp_checksum;
	assign ip_checksum     = res_q.ip_checksum;
	assign too_long        = res_q.too_long;

endmodule

// File: design/udpck_result.sv
module udpck_result (
	input  udpck_pkg::pkt_state_t        st,
	input  udpck_pkg::item_t             item,
	input  logic [udpck_pkg::CFG_SUM_W-1:0] cfg_udp_sum,
	input  logic [udpck_pkg::CFG_SUM_W-1:0] cfg_ip_sum,
	output udpck_pkg::pkt_state_t        st_nxt,
	output udpck_pkg::result_t           res
);
	import udpck_pkg::*;

	logic             full;
	logic             taken;
	logic [7:0]       word_hi;
	logic [7:0]       word_lo;
	logic [15:0]      cnt;
	logic [15:0]      udp_len;
	logic [15:0]      ip_len;
	logic [SUM_W-1:0] udp_total;
	logic [SUM_W-1:0] ip_total;

	assign full  = st.count >= 16'(MAX_PAYLOAD);
	assign taken = item.byte_present && !full;

	always_comb begin
		st_nxt     = st;
		st_nxt.ovf = st.ovf | (item.byte_present & full);
		if (taken) begin
			st_nxt.count = st.count + 16'd1;
			if (st.odd) begin
				st_nxt.sum     = oc_add16(st.sum, {st.pending, item.data_byte});
				st_nxt.pending = 8'd0;
				st_nxt.odd     = 1'b0;
			end else begin
				st_nxt.pending = item.data_byte;
				st_nxt.odd     = 1'b1;
			end
		end
	end

	assign word_hi = st.odd ? st.pending : (taken ? item.data_byte : 8'd0);
	assign word_lo = (st.odd && taken) ? item.data_byte : 8'd0;

	assign cnt     = st.count + {15'd0, taken};
	assign udp_len = cnt + UDP_HDR_BYTES;
	assign ip_len  = cnt + IP_UDP_HDR_BYTES;

	assign udp_total = SUM_W'(st.sum) + SUM_W'({word_hi, word_lo}) + SUM_W'(cfg_udp_sum)
		+ SUM_W'(udp_len) + SUM_W'(udp_len);
	assign ip_total  = SUM_W'(cfg_ip_sum) + SUM_W'(ip_len);

	assign res.udp_length      = udp_len;
	assign res.ip_total_length = ip_len;
	assign res.udp_checksum    = ~fold20(udp_total);
	assign res.ip_checksum     = ~fold20(ip_total);
	assign res.too_long        = st_nxt.ovf;

endmodule

// File: dv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import udpck_pkg::*;

	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_LIMIT = 200000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	cfg_idx_t    cfg_idx = REG_SRC_IP;
	logic [31:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = '0;
	logic        byte_present = 1'b0;
	logic        end_of_payload = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] udp_length;
	logic [15:0] ip_total_length;
	logic [15:0] udp_checksum;
	logic [15:0] ip_checksum;
	logic        too_long;

	item_t   byte_fifo[$];
	result_t sum_fifo[$];
	item_t   cur_req;
	result_t head_sum;
	bit      sink_stall_nx;

	bit idle_on = 1'b1;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;
	int src_gap = 0;
	int sink_gap = 0;

	int n_errors = 0;
	int n_results = 0;
	int n_oversize = 0;
	int n_requests = 0;
	int n_stall_cycles = 0;

	logic [31:0] ip_src_q;
	logic [31:0] ip_dst_q;
	logic [15:0] port_src_q;
	logic [15:0] port_dst_q;

	logic [15:0] acc_sum;
	logic [7:0]  hi_byte;
	logic        have_hi;
	logic [15:0] n_bytes;
	logic        overran;

	udp_ipv4_checksum_engine_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_idx        (cfg_idx),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.byte_present   (byte_present),
		.end_of_payload (end_of_payload),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.udp_length     (udp_length),
		.ip_total_length(ip_total_length),
		.udp_checksum   (udp_checksum),
		.ip_checksum    (ip_checksum),
		.too_long       (too_long)
	);

	always #4 clk = ~clk;

	function automatic logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
		int unsigned t;
		t = 32'(a) + 32'(b);
		t = (t & 32'h0000FFFF) + (t >> 16);
		return t[15:0];
	endfunction

	task automatic flag_error(string msg);
		$display("ERROR @%0t: %s", $time, msg);
		n_errors++;
	endtask

	task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
		if (got !== want)
			flag_error($sformatf("%s got %h want %h", name, got, want));
	endtask

	task automatic clear_packet_state();
		acc_sum = '0;
		hi_byte = '0;
		have_hi = 1'b0;
		n_bytes = '0;
		overran = 1'b0;
	endtask

	task automatic accumulate_request(item_t rq);
		result_t r;
		logic [15:0] s;
		if (rq.byte_present) begin
			if (n_bytes >= MAX_PAYLOAD) begin
				overran = 1'b1;
			end else begin
				if (!have_hi) begin
					hi_byte = rq.data_byte;
					have_hi = 1'b1;
				end else begin
					acc_sum = ones_add(acc_sum, {hi_byte, rq.data_byte});
					hi_byte = '0;
					have_hi = 1'b0;
				end
				n_bytes = n_bytes + 16'd1;
			end
		end
		if (rq.end_of_payload) begin
			r.udp_length = n_bytes + UDP_HDR_BYTES;
			r.ip_total_length = n_bytes + IP_UDP_HDR_BYTES;
			s = acc_sum;
			if (have_hi)
				s = ones_add(s, {hi_byte, 8'h00});
			s = ones_add(s, port_src_q);
			s = ones_add(s, port_dst_q);
			s = ones_add(s, r.udp_length);
			s = ones_add(s, ip_src_q[31:16]);
			s = ones_add(s, ip_src_q[15:0]);
			s = ones_add(s, ip_dst_q[31:16]);
			s = ones_add(s, ip_dst_q[15:0]);
			s = ones_add(s, PROTO_UDP);
			s = ones_add(s, r.udp_length);
			r.udp_checksum = ~s;
			s = IP_VER_IHL;
			s = ones_add(s, r.ip_total_length);
			s = ones_add(s, IP_FLAGS_DF);
			s = ones_add(s, IP_TTL_PROTO);
			s = ones_add(s, ip_src_q[31:16]);
			s = ones_add(s, ip_src_q[15:0]);
			s = ones_add(s, ip_dst_q[31:16]);
			s = ones_add(s, ip_dst_q[15:0]);
			r.ip_checksum = ~s;
			r.too_long = overran;
			if (overran)
				n_oversize++;
			sum_fifo.push_back(r);
			clear_packet_state();
		end
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_SRC_IP: ip_src_q = val;
			REG_DST_IP: ip_dst_q = val;
			REG_SRC_PORT: port_src_q = val[15:0];
			REG_DST_PORT: port_dst_q = val[15:0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic [31:0] sip, logic [31:0] dip, logic [15:0] sp,
			logic [15:0] dp);
		write_reg(REG_SRC_IP, sip);
		write_reg(REG_DST_IP, dip);
		write_reg(REG_SRC_PORT, {16'd0, sp});
		write_reg(REG_DST_PORT, {16'd0, dp});
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic push_req(logic [7:0] b, logic p, logic e);
		item_t it;
		it.data_byte = b;
		it.byte_present = p;
		it.end_of_payload = e;
		byte_fifo.push_back(it);
	endtask

	task automatic queue_packet(int len, bit end_on_byte);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0)
				push_req(8'($urandom), 1'b0, 1'b0);
			push_req(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
		end
		if (!end_on_byte || len == 0)
			push_req(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic queue_random(int budget);
		int used;
		int len;
		used = 0;
		while (used < budget) begin
			case ($urandom_range(0, 19))
				0: len = 0;
				1, 2: len = $urandom_range(25, 200);
				default: len = $urandom_range(1, 24);
			endcase
			queue_packet(len, $urandom_range(0, 1));
			used += len + 1;
		end
	endtask

	task automatic drain();
		int waited;
		waited = 0;
		while ((byte_fifo.size() != 0 || in_valid || sum_fifo.size() != 0) &&
				waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				accumulate_request(cur_req);
				n_requests++;
			end
			if (in_valid && in_stall) begin
				n_stall_cycles++;
			end else if (src_gap > 0) begin
				src_gap--;
				in_valid <= 1'b0;
			end else if (idle_on && $urandom_range(0, 15) == 0) begin
				src_gap = $urandom_range(0, 17);
				in_valid <= 1'b0;
			end else if (byte_fifo.size() != 0) begin
				cur_req = byte_fifo.pop_front();
				data_byte <= cur_req.data_byte;
				byte_present <= cur_req.byte_present;
				end_of_payload <= cur_req.end_of_payload;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				n_results++;
				if (sum_fifo.size() == 0) begin
					flag_error($sformatf("result with no request pending, udp_length %h",
						udp_length));
				end else begin
					head_sum = sum_fifo.pop_front();
					check_field("udp_length", udp_length, head_sum.udp_length);
					check_field("ip_total_length", ip_total_length,
						head_sum.ip_total_length);
					check_field("udp_checksum", udp_checksum, head_sum.udp_checksum);
					check_field("ip_checksum", ip_checksum, head_sum.ip_checksum);
					check_field("too_long", {15'd0, too_long}, {15'd0, head_sum.too_long});
				end
			end
			if (sink_gap > 0) begin
				sink_gap--;
				sink_stall_nx = 1'b1;
			end else if (idle_on && $urandom_range(0, 15) == 0) begin
				sink_gap = $urandom_range(0, 17);
				sink_stall_nx = 1'b1;
			end else begin
				sink_stall_nx = 1'b0;
			end
			out_stall <= sink_stall_nx || (hold_left != 0);
		end
	end

	initial begin
		#4000000;
		$display("FAIL");
		$finish;
	end

	initial begin
		clear_packet_state();
		ip_src_q = '0;
		ip_dst_q = '0;
		port_src_q = '0;
		port_dst_q = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_config(32'h0, 32'h0, 16'h0, 16'h0);
		push_req(8'hA5, 1'b0, 1'b1);
		push_req(8'h00, 1'b0, 1'b0);
		push_req(8'hFF, 1'b1, 1'b1);
		push_req(8'h00, 1'b1, 1'b1);
		// sum folds to all ones with zero registers: checksum stays zero
		push_req(8'hFF, 1'b1, 1'b0);
		push_req(8'hDA, 1'b1, 1'b1);
		push_req(8'h00, 1'b0, 1'b0);
		push_req(8'h00, 1'b1, 1'b0);
		push_req(8'hFF, 1'b0, 1'b0);
		push_req(8'hFF, 1'b1, 1'b0);
		push_req(8'h80, 1'b1, 1'b0);
		push_req(8'h7E, 1'b0, 1'b1);
		push_req(8'h5A, 1'b0, 1'b1);
		push_req(8'hFF, 1'b1, 1'b0);
		push_req(8'hFF, 1'b1, 1'b0);
		push_req(8'hFF, 1'b1, 1'b0);
		push_req(8'hFF, 1'b1, 1'b1);
		push_req(8'h01, 1'b1, 1'b0);
		push_req(8'h7F, 1'b1, 1'b0);
		push_req(8'hFF, 1'b0, 1'b1);
		drain();

		set_config(32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF);
		queue_random(60);
		drain();

		// hold the receiver off while short packets keep coming
		set_config($urandom, $urandom, 16'($urandom), 16'($urandom));
		hold_req = 1'b1;
		for (int i = 0; i < 40; i++)
			queue_packet($urandom_range(0, 4), $urandom_range(0, 1));
		drain();

		set_config(32'h80000000, 32'h7FFFFFFF, 16'h0000, 16'hFFFF);
		queue_random(60);
		queue_packet(MAX_PAYLOAD + 1, 1'b1);
		drain();

		set_config($urandom, $urandom, 16'($urandom), 16'($urandom));
		queue_random(60);
		drain();

		set_config($urandom, $urandom, 16'($urandom), 16'($urandom));
		idle_on = 1'b0;
		queue_random(60);
		drain();

		if (sum_fifo.size() != 0)
			flag_error($sformatf("%0d results never arrived", sum_fifo.size()));
		$display("Covered %0d requests and %0d results, %0d of them oversize.",
			n_requests, n_results, n_oversize);
		$display("Six register settings incl. all-zero and all-ones; input stalled %0d cycles.",
			n_stall_cycles);
		if (n_errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// File: files.f
design/udpck_pkg.sv
design/udpck_result.sv
design/udp_ipv4_checksum_engine_core.sv
dv/tb.sv
